### hw/rtl/lmbp_pkg.sv
// ----------------------------------------------------------------------------
// lmbp_pkg
// Types, constants and helpers shared by the breathing pwm block.
// ----------------------------------------------------------------------------
package lmbp_pkg;

  localparam int unsigned GRID_SIDE = 8;
  localparam int unsigned NUM_PIX   = GRID_SIDE * GRID_SIDE;
  localparam int unsigned COORD_W   = $clog2(GRID_SIDE);
  localparam int unsigned IDX_W     = $clog2(NUM_PIX);
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned HUE_W     = 2;

  localparam logic [CNT_W-1:0] PERIOD = 7'd64;

  localparam logic [HUE_W-1:0] COLOR_OFF    = 2'd0;
  localparam logic [HUE_W-1:0] COLOR_FIRST  = 2'd1;
  localparam logic [HUE_W-1:0] COLOR_SECOND = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] tick;
    logic [CNT_W-1:0] duty;
    logic             phase;
    logic [HUE_W-1:0] hue;
  } pix_t;

  localparam int unsigned PIX_W = $bits(pix_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RMW   = 3'b010,
    ST_EMIT2 = 3'b100
  } state_e;

  // position dependent power-on entry
  function automatic pix_t pix_reset(input logic [COORD_W-1:0] row,
                                     input logic [COORD_W-1:0] col);
    logic [CNT_W-1:0] r1;
    logic [CNT_W-1:0] c1;
    logic [CNT_W-1:0] d;
    pix_t             p;
    r1      = CNT_W'(row) + CNT_W'(1);
    c1      = CNT_W'(col) + CNT_W'(1);
    d       = r1 * c1;
    p.tick  = PERIOD - d;
    p.duty  = d;
    p.phase = 1'b1;
    p.hue   = COLOR_FIRST;
    return p;
  endfunction

  function automatic logic [HUE_W-1:0] hue_next(input logic [HUE_W-1:0] hue);
    return hue[0] ? COLOR_SECOND : COLOR_FIRST;
  endfunction

endpackage

### hw/rtl/led_matrix_breathing_pwm.sv
// ----------------------------------------------------------------------------
// led_matrix_breathing_pwm
// Per-pixel software pwm with a slow fade for an 8x8 led grid.
// ----------------------------------------------------------------------------
// A tick is taken when start is high and busy is low. Each pixel's counter,
// threshold, phase and color live in one 64-entry ram; a tick reads its entry
// through the registered ram read, then updates and writes it back in the next
// cycle. A tick keeps busy high through the update state, and also through a
// second emit state when it causes two writes, since the second write needs a
// strobe cycle of its own. Display writes come out on strobe_o for exactly one
// cycle each and cannot be stalled; last_write_o marks the final write of a
// tick. Entries not yet written since reset read as their position dependent
// power-on values, so no clearing pass is needed.
module led_matrix_breathing_pwm
  import lmbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] pixel_col_i,
  input  logic [COORD_W-1:0] pixel_row_i,
  output logic               strobe_o,
  output logic [COORD_W-1:0] write_col_o,
  output logic [COORD_W-1:0] write_row_o,
  output logic [HUE_W-1:0]   write_color_o,
  output logic               last_write_o
);

  state_e state_q, state_d;

  logic [COORD_W-1:0] col_q, row_q;
  logic [IDX_W-1:0]   idx_q;
  logic [NUM_PIX-1:0] valid_q;
  logic [HUE_W-1:0]   pend_color_q, pend_color_d;

  logic               strobe_q, strobe_d;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic [HUE_W-1:0]   out_color_q, out_color_d;
  logic               out_last_q, out_last_d;

  logic       accept;
  logic       ram_we;
  pix_t       ram_rdata;
  pix_t       cur, upd;
  logic       match, period_end;
  logic [CNT_W-1:0] duty_dec;
  logic [HUE_W-1:0] color1, color2;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign ram_we = (state_q == ST_RMW);

  lmbp_ram #(
    .Width(PIX_W),
    .Depth(NUM_PIX)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(upd),
    .re_i   (accept),
    .raddr_i({pixel_row_i, pixel_col_i}),
    .rdata_o(ram_rdata)
  );

  // pixel update
  always_comb begin
    cur        = valid_q[idx_q] ? ram_rdata : pix_reset(row_q, col_q);
    match      = (cur.tick == cur.duty);
    period_end = (cur.tick == PERIOD);
    color1     = cur.phase ? COLOR_OFF : cur.hue;
    upd        = cur;
    duty_dec   = cur.duty - CNT_W'(1);
    if (period_end) begin
      upd.tick = '0;
      upd.duty = duty_dec;
      if (duty_dec == '0) begin
        upd.duty  = PERIOD;
        upd.phase = ~cur.phase;
        if (cur.phase) begin
          upd.hue = hue_next(cur.hue);
        end
      end
    end
    color2   = upd.phase ? upd.hue : COLOR_OFF;
    upd.tick = upd.tick + CNT_W'(1);
  end

  always_comb begin
    state_d      = state_q;
    strobe_d     = 1'b0;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    pend_color_d = pend_color_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        state_d = ST_IDLE;
        if (match) begin
          strobe_d     = 1'b1;
          out_color_d  = color1;
          out_last_d   = !period_end;
          pend_color_d = color2;
          if (period_end) begin
            state_d = ST_EMIT2;
          end
        end else if (period_end) begin
          strobe_d    = 1'b1;
          out_color_d = color2;
          out_last_d  = 1'b1;
        end
      end
      ST_EMIT2: begin
        state_d     = ST_IDLE;
        strobe_d    = 1'b1;
        out_color_d = pend_color_q;
        out_last_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      if (ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
      idx_q <= {pixel_row_i, pixel_col_i};
    end
    if (ram_we) begin
      out_col_q <= col_q;
      out_row_q <= row_q;
    end
    out_color_q  <= out_color_d;
    out_last_q   <= out_last_d;
    pend_color_q <= pend_color_d;
  end

  assign strobe_o      = strobe_q;
  assign write_col_o   = out_col_q;
  assign write_row_o   = out_row_q;
  assign write_color_o = out_color_q;
  assign last_write_o  = out_last_q;

`ifndef SYNTHESIS
  // a tick goes straight to the read-modify-write cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RMW)
    else $error("accepted tick did not enter rmw");

  // the second write of a tick always follows a first one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT2 |-> strobe_o && !last_write_o)
    else $error("second write without a first");

  // a non-final write is followed by the final write of the same pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_write_o |=> strobe_o && last_write_o
      && write_col_o == $past(write_col_o) && write_row_o == $past(write_row_o))
    else $error("final write missing after first write");

  // writes only appear right after an update or a pending second write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_d |-> state_q == ST_RMW || state_q == ST_EMIT2)
    else $error("write strobe outside of a tick");
`endif

endmodule

### hw/rtl/lmbp_ram.sv
// ----------------------------------------------------------------------------
// lmbp_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module lmbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/led_matrix_breathing_pwm_tb.sv
// ----------------------------------------------------------------------------
// led_matrix_breathing_pwm_tb
// Drives pixel ticks into the breathing pwm block, with random gaps and drain
// pauses. Each display write is checked field by field against the fixed entry
// of a typed directed tick, else against an in-bench model of each pixel's
// counter, threshold, phase and color. Directed ticks from a short table run
// first; a biased random run then keeps two pixels hot to reach double writes.
// ----------------------------------------------------------------------------
module led_matrix_breathing_pwm_tb;
  import lmbp_pkg::*;

  localparam int RAND_ITEMS     = 1400;
  localparam int NUM_DIR        = 16;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [HUE_W-1:0]   color;
    logic               last;
  } disp_write_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               typed;
    logic [1:0]         n;
    logic [HUE_W-1:0]   c0;
    logic [HUE_W-1:0]   c1;
  } dir_tick_t;

  // col, row, typed, writes, first color, second color
  localparam dir_tick_t DIR_TAB [NUM_DIR] = '{
    '{3'd0, 3'd0, 1'b1, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd0, 3'd0, 1'b1, 2'd1, COLOR_OFF,   COLOR_OFF},
    '{3'd7, 3'd3, 1'b1, 2'd1, COLOR_OFF,   COLOR_OFF},
    '{3'd3, 3'd7, 1'b1, 2'd1, COLOR_OFF,   COLOR_OFF},
    '{3'd7, 3'd3, 1'b1, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd7, 3'd7, 1'b1, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd0, 3'd7, 1'b1, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd7, 3'd0, 1'b1, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd1, 3'd0, 1'b1, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd1, 3'd0, 1'b1, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd1, 3'd0, 1'b1, 2'd1, COLOR_FIRST, COLOR_OFF},
    '{3'd1, 3'd0, 1'b1, 2'd1, COLOR_OFF,   COLOR_OFF},
    '{3'd0, 3'd0, 1'b0, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd5, 3'd5, 1'b0, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd2, 3'd6, 1'b0, 2'd0, COLOR_OFF,   COLOR_OFF},
    '{3'd6, 3'd1, 1'b0, 2'd0, COLOR_OFF,   COLOR_OFF}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic [COORD_W-1:0] pixel_col_i = '0;
  logic [COORD_W-1:0] pixel_row_i = '0;
  logic               strobe_o;
  logic [COORD_W-1:0] write_col_o;
  logic [COORD_W-1:0] write_row_o;
  logic [HUE_W-1:0]   write_color_o;
  logic               last_write_o;

  logic [CNT_W-1:0] tick_cnt  [NUM_PIX];
  logic [CNT_W-1:0] duty_thr  [NUM_PIX];
  logic             phase_q   [NUM_PIX];
  logic [HUE_W-1:0] hue_q     [NUM_PIX];

  disp_write_t pending_writes[$];
  int          mismatch_cnt     = 0;
  int          burst_left       = 0;

  led_matrix_breathing_pwm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .strobe_o      (strobe_o),
    .write_col_o   (write_col_o),
    .write_row_o   (write_row_o),
    .write_color_o (write_color_o),
    .last_write_o  (last_write_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void grid_power_on();
    int d;
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        d = (r + 1) * (c + 1);
        tick_cnt[r * GRID_SIDE + c] = CNT_W'(64 - d);
        duty_thr[r * GRID_SIDE + c] = CNT_W'(d);
        phase_q[r * GRID_SIDE + c]  = 1'b1;
        hue_q[r * GRID_SIDE + c]    = COLOR_FIRST;
      end
    end
  endfunction

  // advance one pixel by a tick and return the display writes it causes
  function automatic void pwm_tick_predict(input logic [COORD_W-1:0] col,
                                           input logic [COORD_W-1:0] row,
                                           output int n,
                                           output logic [HUE_W-1:0] c0,
                                           output logic [HUE_W-1:0] c1);
    int               idx;
    logic [HUE_W-1:0] color;
    idx = int'(row) * GRID_SIDE + int'(col);
    n   = 0;
    c0  = COLOR_OFF;
    c1  = COLOR_OFF;
    if (tick_cnt[idx] == duty_thr[idx]) begin
      c0 = phase_q[idx] ? COLOR_OFF : hue_q[idx];
      n  = 1;
    end
    if (tick_cnt[idx] == PERIOD) begin
      tick_cnt[idx] = '0;
      duty_thr[idx] = duty_thr[idx] - 1'b1;
      if (duty_thr[idx] == '0) begin
        duty_thr[idx] = PERIOD;
        phase_q[idx]  = ~phase_q[idx];
        if (!phase_q[idx]) begin
          hue_q[idx] = (hue_q[idx] % 2 == 1) ? COLOR_SECOND : COLOR_FIRST;
        end
      end
      color = phase_q[idx] ? hue_q[idx] : COLOR_OFF;
      if (n == 0) begin
        c0 = color;
      end else begin
        c1 = color;
      end
      n++;
    end
    tick_cnt[idx] = tick_cnt[idx] + 1'b1;
  endfunction

  function automatic void queue_writes(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] row, input int n,
                                       input logic [HUE_W-1:0] c0,
                                       input logic [HUE_W-1:0] c1);
    for (int k = 0; k < n; k++) begin
      pending_writes.push_back('{col, row, (k == 0) ? c0 : c1, k == n - 1});
    end
  endfunction

  // holds the tick until it is taken, then records what it should write
  task automatic send_tick(input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input dir_tick_t fixed);
    int               n;
    logic [HUE_W-1:0] c0;
    logic [HUE_W-1:0] c1;
    start       <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (busy);
    pwm_tick_predict(col, row, n, c0, c1);
    if (fixed.typed) begin
      queue_writes(col, row, int'(fixed.n), fixed.c0, fixed.c1);
    end else begin
      queue_writes(col, row, n, c0, c1);
    end
  endtask

  task automatic idle_gap();
    int r;
    int len;
    if (burst_left > 0) begin
      burst_left--;
      len = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) begin
        burst_left = $urandom_range(20, 60);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = 0;
      end else if (r < 90) begin
        len = $urandom_range(1, 3);
      end else if (r < 97) begin
        len = $urandom_range(4, 10);
      end else begin
        len = $urandom_range(11, 40);
      end
    end
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic drain_writes();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    disp_write_t want;
    if (rst_ni && strobe_o) begin
      if (pending_writes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected write col %0d row %0d color %0d last %0d", write_col_o,
                   write_row_o, write_color_o, last_write_o);
        end
      end else begin
        want = pending_writes.pop_front();
        if (want.col !== write_col_o || want.row !== write_row_o ||
            want.color !== write_color_o || want.last !== last_write_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("write mismatch: exp col %0d row %0d color %0d last %0d, got %0d %0d %0d %0d",
                     want.col, want.row, want.color, want.last, write_col_o,
                     write_row_o, write_color_o, last_write_o);
          end
        end
      end
    end
  end

  initial begin
    dir_tick_t          no_fix;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    int                 r;
    int                 items;
    no_fix = '0;
    grid_power_on();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_tick(DIR_TAB[i].col, DIR_TAB[i].row, DIR_TAB[i]);
      idle_gap();
    end

    // hot pixels reach double writes
    items = 0;
    while (items < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        col = 3'd0;
        row = 3'd0;
      end else if (r < 65) begin
        col = 3'd7;
        row = 3'd7;
      end else begin
        col = COORD_W'($urandom_range(0, GRID_SIDE - 1));
        row = COORD_W'($urandom_range(0, GRID_SIDE - 1));
      end
      send_tick(col, row, no_fix);
      items++;
      if (items == RAND_ITEMS / 2 || $urandom_range(0, 99) == 0) begin
        drain_writes();
      end else begin
        idle_gap();
      end
    end

    drain_writes();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
